// ===== hdl/ssid_pkg.sv =====
// shared types and constants for the sorted set insert/delete unit
package ssid_pkg;

  localparam int VAL_W  = 32;
  localparam int SIZE_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_DELETED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FULL       = 3'd4,
    ST_DUMP_ENTRY = 3'd5,
    ST_DUMP_EMPTY = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  head;
  } cell_ctrl_t;

endpackage

// ===== hdl/ssid_cell.sv =====
// one storage cell of the sorted row: compare against the operand and shift
module ssid_cell
  import ssid_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             occ,
  input  logic             occ_next,
  input  logic             lt_prev,
  input  logic [VAL_W-1:0] e_prev,
  input  logic [VAL_W-1:0] e_next,
  output logic [VAL_W-1:0] e,
  output logic             lt,
  output logic             eq
);

  logic [VAL_W-1:0] e_r;
  logic [VAL_W-1:0] e_nxt;
  logic [VAL_W-1:0] key_e;
  logic [VAL_W-1:0] key_v;

  // flip the sign bit so an unsigned compare keeps signed order
  assign key_e = e_r ^ {1'b1, {(VAL_W-1){1'b0}}};
  assign key_v = ctrl.value ^ {1'b1, {(VAL_W-1){1'b0}}};

  assign lt = occ && (key_e < key_v);
  assign eq = occ && (e_r == ctrl.value);
  assign e  = e_r;

  always_comb begin
    case (ctrl.op)
      OP_INSERT: e_nxt = lt ? e_r : (lt_prev ? ctrl.value : e_prev);
      OP_DELETE: e_nxt = lt ? e_r : e_next;
      OP_ROTATE: e_nxt = occ_next ? e_next : ctrl.head;
      default:   e_nxt = e_r;
    endcase
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

endmodule

// ===== hdl/sorted_set_insert_delete_unit.sv =====
// top level: sorted set of signed values kept in a row of compare/shift cells
// Holds up to CAPACITY distinct signed 32-bit values in ascending order, one value per
// cell. For an insert or a delete every cell compares its value with the operand in
// parallel and moves up, down or stays in the same cycle, so with the result side ready
// a new insert or delete is taken every cycle and its single result appears in the
// output register in the next cycle. A dump of an empty set gives one result; otherwise
// the row rotates by one cell each cycle that the result side is ready and the head
// cell is sent out, and the input is blocked until the last entry has been sent.
// Command code 3 is taken and dropped. Inputs: in_tuser = cmd, in_tdata = value.
// Results: out_tuser = status, out_tdata = element and size, out_tlast = last.
module sorted_set_insert_delete_unit
  import ssid_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] element, [38:32] size, [39] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);

  fsm_t             state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    dump_idx_r, dump_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_elem_r, out_elem_nxt;
  logic [CW-1:0]    out_size_r, out_size_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] e [CAPACITY];
  logic [CAPACITY-1:0] lt, eq, occ;

  logic slot_free, in_fire, any_eq, is_full, dump_last;
  cmd_t cmd;

  assign cmd       = cmd_t'(in_tuser);
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == FSM_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign any_eq    = |eq;
  assign is_full   = count_r == CW'(CAPACITY);
  assign dump_last = dump_idx_r == (count_r - CW'(1));

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic             lt_prev_w, occ_next_w;
      logic [VAL_W-1:0] e_prev_w, e_next_w;

      assign occ[gi] = count_r > CW'(gi);

      if (gi == 0) begin : g_first
        assign lt_prev_w = 1'b1;
        assign e_prev_w  = ctrl.value;
      end else begin : g_mid
        assign lt_prev_w = lt[gi-1];
        assign e_prev_w  = e[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign occ_next_w = 1'b0;
        assign e_next_w   = e[gi];
      end else begin : g_inner
        assign occ_next_w = occ[gi+1];
        assign e_next_w   = e[gi+1];
      end

      ssid_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occ      (occ[gi]),
        .occ_next (occ_next_w),
        .lt_prev  (lt_prev_w),
        .e_prev   (e_prev_w),
        .e_next   (e_next_w),
        .e        (e[gi]),
        .lt       (lt[gi]),
        .eq       (eq[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire && cmd == CMD_DUMP && count_r != '0) state_nxt = FSM_DUMP;
      end
      FSM_DUMP: begin
        if (slot_free && dump_last) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // datapath control and result register loads
  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.value     = in_tdata;
    ctrl.head      = e[0];
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_size_nxt   = out_size_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          out_elem_nxt = in_tdata;
          out_last_nxt = 1'b1;
          out_size_nxt = count_r;
          case (cmd)
            CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (any_eq) begin
                out_status_nxt = ST_DUPLICATE;
              end else if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.op        = OP_INSERT;
                count_nxt      = count_r + CW'(1);
                out_size_nxt   = count_r + CW'(1);
                out_status_nxt = ST_INSERTED;
              end
            end
            CMD_DELETE: begin
              out_valid_nxt = 1'b1;
              if (any_eq) begin
                ctrl.op        = OP_DELETE;
                count_nxt      = count_r - CW'(1);
                out_size_nxt   = count_r - CW'(1);
                out_status_nxt = ST_DELETED;
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            CMD_DUMP: begin
              dump_idx_nxt = '0;
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_DUMP_EMPTY;
                out_elem_nxt   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_DUMP: begin
        if (slot_free) begin
          // send the head and rotate the occupied part of the row
          ctrl.op        = OP_ROTATE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DUMP_ENTRY;
          out_elem_nxt   = e[0];
          out_size_nxt   = count_r;
          out_last_nxt   = dump_last;
          dump_idx_nxt   = dump_idx_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_size_r   <= out_size_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, SIZE_W'(out_size_r), out_elem_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/ssid_checker.sv =====
// port-level checks for the sorted set unit, bound to the top level
module ssid_port_checker
  import ssid_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DUMP_EMPTY |->
      out_tlast && out_tdata[38:32] == 7'd0 && out_tdata[31:0] == 32'd0)
    else $error("empty dump result malformed");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_INSERTED || out_tuser == ST_DUPLICATE
      || out_tuser == ST_DELETED || out_tuser == ST_NOT_FOUND
      || out_tuser == ST_FULL) |-> out_tlast)
    else $error("single result not marked last");

  a_dump_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_INSERTED || out_tuser == ST_DUMP_ENTRY)
      |-> out_tdata[38:32] != 7'd0)
    else $error("nonempty result reports size zero");

endmodule

bind sorted_set_insert_delete_unit ssid_port_checker u_ssid_port_checker (.*);
